// ===== rtl/core/sst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the stiffness table interpolator
// Item layouts, table geometry and configuration register indexes.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int NUM_TABLES  = 7;
    localparam int LOSS_TABLE  = 6;
    localparam int NUM_DIRS    = 6;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MEM_DEPTH   = NUM_TABLES * TABLE_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // table select with no table behind it; loads to it are dropped
    localparam logic [2:0] BAD_TABLE = 3'd7;

    localparam logic REG_COMPLEX_MODE = 1'b0;
    localparam logic REG_DAMPING_KIND = 1'b1;

    localparam logic [1:0] DAMP_HYSTERETIC = 2'd1;
    localparam logic [1:0] DAMP_VISCOUS    = 2'd2;

    typedef struct packed {
        logic               op;
        logic [2:0]         table_select;
        logic [5:0]         entry_index;
        logic [31:0]        point_frequency;
        logic signed [31:0] point_value;
        logic [31:0]        query_frequency;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         direction;
        logic signed [31:0] stiffness_real;
        logic signed [31:0] stiffness_imag;
        logic signed [31:0] loss_used;
        logic               status;
        logic               last;
    } result_t;

endpackage

// ===== rtl/core/spring_stiffness_table_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_stiffness_table_interpolator: piecewise linear stiffness lookup
// Seven breakpoint tables, sequential scan, shared shift-add multiplier and
// restoring divider; six results per evaluate item.
// ----------------------------------------------------------------------------
// A load item leaves busy low. An evaluate item scans the loss table and
// then the six stiffness tables, one read request and one data state per
// stored breakpoint through the single read port of the breakpoint memory; an
// interpolated table adds 32 multiply and 64 divide steps, and each complex
// result adds 64 more multiply steps; all multiplies share one shift-add unit.
// Each result is shown for exactly one cycle on result_valid and cannot be
// held off; the six come out in direction order, the last flagged with last.

module spring_stiffness_table_interpolator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sst_pkg::in_item_t   cmd,
    input  logic                wr_en,
    input  logic                wr_index,
    input  logic [1:0]          wr_data,
    output logic                result_valid,
    output sst_pkg::result_t    result
);

    typedef enum logic [3:0] {
        S_IDLE, S_TBL_START, S_SCAN_REQ, S_SCAN_DATA, S_DECIDE,
        S_MUL, S_DIV, S_FIN, S_TBL_DONE, S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_INTERP, PH_IMAG_A, PH_IMAG_B
    } phase_t;

    state_t                     state_reg;
    phase_t                     phase_reg;
    logic                       complex_mode_reg;
    logic [1:0]                 damping_kind_reg;
    logic [sst_pkg::LEN_W-1:0]  len_reg [sst_pkg::NUM_TABLES];
    logic [63:0]                mem [sst_pkg::MEM_DEPTH];
    logic [63:0]                mem_q;
    logic [sst_pkg::ADDR_W-1:0] rd_addr;

    logic [2:0]                 tbl_reg;
    logic [sst_pkg::IDX_W-1:0]  k_reg;
    logic [5:0]                 cnt_reg;
    logic [31:0]                q_reg;
    logic                       status_reg;
    logic [31:0]                first_f_reg, first_v_reg;
    logic [31:0]                prev_f_reg, prev_v_reg;
    logic                       found_reg;
    logic [31:0]                p0_f_reg, p0_v_reg, p1_f_reg, p1_v_reg;
    logic [95:0]                acc_reg, mcand_reg;
    logic [31:0]                mplier_reg;
    logic [31:0]                den_reg;
    logic [63:0]                dvd_reg;
    logic [32:0]                rem_reg;
    logic                       neg_reg;
    logic [31:0]                val_reg;
    logic [31:0]                eta_reg;
    logic                       result_valid_reg;
    sst_pkg::result_t           result_reg;

    logic                       accept;
    logic [sst_pkg::LEN_W-1:0]  cur_len;
    logic [32:0]                dv;
    logic [32:0]                rem_sh;
    logic                       rem_ge;
    logic [33:0]                interp;
    logic [95:0]                mul_sum;
    logic [63:0]                imag_mag;
    logic [31:0]                imag_sat;
    logic                       prod_neg;
    logic [31:0]                abs_k, abs_eta;
    logic                       use_imag;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign cur_len  = len_reg[tbl_reg];
    assign rd_addr  = sst_pkg::ADDR_W'(tbl_reg * sst_pkg::TABLE_DEPTH)
                    + sst_pkg::ADDR_W'(k_reg);
    assign dv       = {p1_v_reg[31], p1_v_reg} - {p0_v_reg[31], p0_v_reg};
    assign rem_sh   = {rem_reg[31:0], dvd_reg[63]};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign interp   = neg_reg ? {{2{p0_v_reg[31]}}, p0_v_reg} - {1'b0, dvd_reg[32:0]}
                              : {{2{p0_v_reg[31]}}, p0_v_reg} + {1'b0, dvd_reg[32:0]};
    assign mul_sum  = acc_reg + (mplier_reg[0] ? mcand_reg : 96'd0);
    assign abs_k    = val_reg[31] ? (32'd0 - val_reg) : val_reg;
    assign abs_eta  = eta_reg[31] ? (32'd0 - eta_reg) : eta_reg;
    assign prod_neg = val_reg[31] ^ eta_reg[31];
    assign use_imag = complex_mode_reg && !status_reg;
    assign imag_mag = acc_reg[95:32];

    always_comb
    begin
        if (prod_neg)
        begin
            imag_sat = (imag_mag > 64'h8000_0000) ? 32'h8000_0000
                                                  : (32'd0 - imag_mag[31:0]);
        end
        else
        begin
            imag_sat = (imag_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : imag_mag[31:0];
        end
    end

    // breakpoint memory: {frequency, value}
    always_ff @(posedge clk)
    begin
        if (accept && cmd.op == sst_pkg::OP_LOAD && cmd.table_select != sst_pkg::BAD_TABLE
            && 32'(cmd.entry_index) < 32'(sst_pkg::TABLE_DEPTH))
        begin
            mem[sst_pkg::ADDR_W'(cmd.table_select * sst_pkg::TABLE_DEPTH)
                + sst_pkg::ADDR_W'(cmd.entry_index)]
                <= {cmd.point_frequency, cmd.point_value};
        end
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complex_mode_reg <= 1'b1;
            damping_kind_reg <= 2'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                sst_pkg::REG_COMPLEX_MODE: complex_mode_reg <= wr_data[0];
                sst_pkg::REG_DAMPING_KIND: damping_kind_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_INTERP;
            result_valid_reg <= 1'b0;
            tbl_reg          <= 3'd0;
            k_reg            <= '0;
            cnt_reg          <= '0;
            for (int i = 0; i < sst_pkg::NUM_TABLES; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.op == sst_pkg::OP_LOAD)
                        begin
                            if (cmd.table_select != sst_pkg::BAD_TABLE
                                && 32'(cmd.entry_index) < 32'(sst_pkg::TABLE_DEPTH))
                            begin
                                len_reg[cmd.table_select] <=
                                    sst_pkg::LEN_W'(cmd.entry_index) + 1'b1;
                            end
                        end
                        else
                        begin
                            q_reg      <= cmd.query_frequency;
                            status_reg <= complex_mode_reg
                                          && damping_kind_reg != sst_pkg::DAMP_HYSTERETIC
                                          && damping_kind_reg != sst_pkg::DAMP_VISCOUS;
                            tbl_reg    <= 3'(sst_pkg::LOSS_TABLE);
                            state_reg  <= S_TBL_START;
                        end
                    end
                end
                S_TBL_START:
                begin
                    k_reg     <= '0;
                    found_reg <= 1'b0;
                    if (cur_len == '0)
                    begin
                        val_reg   <= 32'd0;
                        state_reg <= S_TBL_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_REQ;
                    end
                end
                S_SCAN_REQ:
                begin
                    state_reg <= S_SCAN_DATA;
                end
                S_SCAN_DATA:
                begin
                    if (k_reg == '0)
                    begin
                        first_f_reg <= mem_q[63:32];
                        first_v_reg <= mem_q[31:0];
                    end
                    else if (prev_f_reg <= q_reg && mem_q[63:32] > q_reg)
                    begin
                        found_reg <= 1'b1;
                        p0_f_reg  <= prev_f_reg;
                        p0_v_reg  <= prev_v_reg;
                        p1_f_reg  <= mem_q[63:32];
                        p1_v_reg  <= mem_q[31:0];
                    end
                    prev_f_reg <= mem_q[63:32];
                    prev_v_reg <= mem_q[31:0];
                    if (sst_pkg::LEN_W'(k_reg) == cur_len - 1'b1)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_SCAN_REQ;
                    end
                end
                S_DECIDE:
                begin
                    // prev now holds the last breakpoint of the table
                    priority if (q_reg <= first_f_reg)
                    begin
                        val_reg   <= first_v_reg;
                        state_reg <= S_TBL_DONE;
                    end
                    else if (q_reg >= prev_f_reg)
                    begin
                        val_reg   <= prev_v_reg;
                        state_reg <= S_TBL_DONE;
                    end
                    else if (!found_reg)
                    begin
                        val_reg   <= first_v_reg;
                        state_reg <= S_TBL_DONE;
                    end
                    else
                    begin
                        neg_reg    <= dv[32];
                        mcand_reg  <= {63'd0, (dv[32] ? (33'd0 - dv) : dv)};
                        mplier_reg <= q_reg - p0_f_reg;
                        den_reg    <= p1_f_reg - p0_f_reg;
                        acc_reg    <= '0;
                        cnt_reg    <= 6'd31;
                        phase_reg  <= PH_INTERP;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    acc_reg    <= mul_sum;
                    mcand_reg  <= {mcand_reg[94:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[31:1]};
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        unique case (phase_reg)
                            PH_INTERP:
                            begin
                                dvd_reg   <= mul_sum[63:0];
                                rem_reg   <= '0;
                                cnt_reg   <= 6'd63;
                                state_reg <= S_DIV;
                            end
                            PH_IMAG_A:
                            begin
                                mcand_reg  <= {32'd0, mul_sum[63:0]};
                                acc_reg    <= '0;
                                mplier_reg <= abs_k;
                                cnt_reg    <= 6'd31;
                                phase_reg  <= PH_IMAG_B;
                            end
                            PH_IMAG_B:
                            begin
                                state_reg <= S_EMIT;
                            end
                            default:
                            begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                    dvd_reg <= {dvd_reg[62:0], rem_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    val_reg   <= interp[31:0];
                    state_reg <= S_TBL_DONE;
                end
                S_TBL_DONE:
                begin
                    if (tbl_reg == 3'(sst_pkg::LOSS_TABLE))
                    begin
                        eta_reg   <= val_reg;
                        tbl_reg   <= 3'd0;
                        state_reg <= S_TBL_START;
                    end
                    else if (use_imag)
                    begin
                        // |eta| * c, then times |k|; keep bits above 32
                        mcand_reg  <= {64'd0, abs_eta};
                        mplier_reg <= (damping_kind_reg == sst_pkg::DAMP_VISCOUS)
                                      ? q_reg : 32'h0001_0000;
                        acc_reg    <= '0;
                        cnt_reg    <= 6'd31;
                        phase_reg  <= PH_IMAG_A;
                        state_reg  <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    result_valid_reg          <= 1'b1;
                    result_reg.direction      <= tbl_reg;
                    result_reg.stiffness_real <= val_reg;
                    result_reg.stiffness_imag <= use_imag ? imag_sat : 32'd0;
                    result_reg.loss_used      <= eta_reg;
                    result_reg.status         <= status_reg;
                    result_reg.last           <= (tbl_reg == 3'(sst_pkg::NUM_DIRS - 1));
                    if (tbl_reg == 3'(sst_pkg::NUM_DIRS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        tbl_reg   <= tbl_reg + 1'b1;
                        state_reg <= S_TBL_START;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
